FILE: hdl/key_debounce_autorepeat_defines.svh
// Assertion macros used by the verification code of the key debounce block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef KEY_DEBOUNCE_AUTOREPEAT_DEFINES_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KDA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key_debounce_autorepeat: check failed");

// Next-cycle implication, checked outside reset.
`define KDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key_debounce_autorepeat: check failed");

`endif

FILE: hdl/kda_pkg.sv
// ----------------------------------------------------------------------------
// kda_pkg
// Shared types and constants of the key debounce and auto-repeat block.
// ----------------------------------------------------------------------------
package kda_pkg;

  // Default sizes handed to the top level.
  localparam int KEY_COUNT_DEFAULT   = 8;
  localparam int COUNT_WIDTH_DEFAULT = 16;

  // Fixed field widths.
  localparam int LEVEL_W     = 8;
  localparam int EVT_KEYS    = 8;
  localparam int KEY_IDX_W   = 3;
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 2;

  // Depth of the tick queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_DELAY   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_DELAY    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_PERIOD = 2'd2;

  // Register values after reset.
  localparam logic [CFG_W-1:0] PRESS_DELAY_RESET   = 16'd5;
  localparam logic [CFG_W-1:0] HOLD_DELAY_RESET    = 16'd50;
  localparam logic [CFG_W-1:0] REPEAT_PERIOD_RESET = 16'd10;

  // Per-key debounce mode.
  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_ON     = 2'd1,
    MODE_REPEAT = 2'd2
  } key_mode_t;

  // Events of one scan tick: which keys fire, and whether each is a make.
  typedef struct packed {
    logic [EVT_KEYS-1:0] hit;
    logic [EVT_KEYS-1:0] make;
  } tick_evt_t;

endpackage

FILE: hdl/kda_front.sv
// ----------------------------------------------------------------------------
// kda_front
// Configuration registers and per-key debounce state; turns one scan tick
// into an event record for the tick queue.
// ----------------------------------------------------------------------------
module kda_front #(
  parameter int KEY_COUNT   = kda_pkg::KEY_COUNT_DEFAULT,
  parameter int COUNT_WIDTH = kda_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [kda_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kda_pkg::CFG_W-1:0]       cfg_data,
  input  logic                           accept,
  input  logic [kda_pkg::LEVEL_W-1:0]     key_levels,
  output logic                           evt_push,
  output kda_pkg::tick_evt_t             evt
);
  import kda_pkg::*;

  // Keys past KEY_COUNT are not read and never leave off,
  // so they need no state.
  localparam int ACTIVE_KEYS = (KEY_COUNT < EVT_KEYS) ? KEY_COUNT : EVT_KEYS;
  localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [CFG_W-1:0]       press_delay;
  logic [CFG_W-1:0]       hold_delay;
  logic [CFG_W-1:0]       repeat_period;
  key_mode_t              mode      [ACTIVE_KEYS];
  key_mode_t              mode_next [ACTIVE_KEYS];
  logic [COUNT_WIDTH-1:0] count      [ACTIVE_KEYS];
  logic [COUNT_WIDTH-1:0] count_next [ACTIVE_KEYS];
  logic [COUNT_WIDTH-1:0] cnt_inc    [ACTIVE_KEYS];
  logic [ACTIVE_KEYS-1:0] held;
  logic [ACTIVE_KEYS-1:0] press_hit;
  logic [ACTIVE_KEYS-1:0] hold_hit;
  logic [ACTIVE_KEYS-1:0] rep_hit;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      press_delay   <= PRESS_DELAY_RESET;
      hold_delay    <= HOLD_DELAY_RESET;
      repeat_period <= REPEAT_PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PRESS_DELAY:   press_delay   <= cfg_data;
        REG_HOLD_DELAY:    hold_delay    <= cfg_data;
        REG_REPEAT_PERIOD: repeat_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturating increment and threshold compares, one set per key.
  always_comb begin
    for (int k = 0; k < ACTIVE_KEYS; k++) begin
      held[k]      = key_levels[k];
      cnt_inc[k]   = (count[k] == CNT_MAX) ? count[k] : count[k] + 1'b1;
      press_hit[k] = CMP_W'(cnt_inc[k]) >= CMP_W'(press_delay);
      hold_hit[k]  = CMP_W'(cnt_inc[k]) >= CMP_W'(hold_delay);
      rep_hit[k]   = CMP_W'(cnt_inc[k]) >= CMP_W'(repeat_period);
    end
  end

  // Next mode and counter of every key.
  always_comb begin
    for (int k = 0; k < ACTIVE_KEYS; k++) begin
      mode_next[k]  = mode[k];
      count_next[k] = count[k];
      case (mode[k])
        MODE_OFF: begin
          if (held[k]) begin
            if (press_hit[k]) begin
              mode_next[k]  = MODE_ON;
              count_next[k] = '0;
            end else begin
              count_next[k] = cnt_inc[k];
            end
          end
        end
        MODE_ON: begin
          if (!held[k]) begin
            mode_next[k]  = MODE_OFF;
            count_next[k] = '0;
          end else if (hold_hit[k]) begin
            mode_next[k]  = MODE_REPEAT;
            count_next[k] = '0;
          end else begin
            count_next[k] = cnt_inc[k];
          end
        end
        MODE_REPEAT: begin
          if (!held[k]) begin
            mode_next[k]  = MODE_OFF;
            count_next[k] = '0;
          end else if (rep_hit[k]) begin
            count_next[k] = '0;
          end else begin
            count_next[k] = cnt_inc[k];
          end
        end
        default: begin
          // The spare mode code acts as on without the hold transition.
          if (!held[k]) begin
            mode_next[k]  = MODE_OFF;
            count_next[k] = '0;
          end else begin
            count_next[k] = cnt_inc[k];
          end
        end
      endcase
    end
  end

  // Events of this tick, one bit per key.
  always_comb begin
    evt = '0;
    for (int k = 0; k < ACTIVE_KEYS; k++) begin
      case (mode[k])
        MODE_OFF: begin
          evt.hit[k]  = held[k] && press_hit[k];
          evt.make[k] = 1'b1;
        end
        MODE_ON: begin
          evt.hit[k]  = !held[k] || hold_hit[k];
          evt.make[k] = held[k];
        end
        MODE_REPEAT: begin
          evt.hit[k]  = !held[k] || rep_hit[k];
          evt.make[k] = held[k];
        end
        default: begin
          evt.hit[k]  = !held[k];
          evt.make[k] = 1'b0;
        end
      endcase
    end
    evt_push = accept && (|evt.hit);
  end

  // Key state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ACTIVE_KEYS; k++) begin
        mode[k]  <= MODE_OFF;
        count[k] <= '0;
      end
    end else if (accept) begin
      for (int k = 0; k < ACTIVE_KEYS; k++) begin
        mode[k]  <= mode_next[k];
        count[k] <= count_next[k];
      end
    end
  end

endmodule

FILE: hdl/kda_queue.sv
// ----------------------------------------------------------------------------
// kda_queue
// Short queue of tick event records between the front and the back.
// ----------------------------------------------------------------------------
module kda_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  kda_pkg::tick_evt_t push_data,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output kda_pkg::tick_evt_t head
);
  import kda_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tick_evt_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_pop;

  // Status and head read.
  always_comb begin
    full       = (fill == CNT_W'(QUEUE_DEPTH));
    head_valid = (fill != '0);
    head       = slots[rd_ptr];
    do_pop     = pop && head_valid;
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/kda_back.sv
// ----------------------------------------------------------------------------
// kda_back
// Serializes the events of the head tick record in key order into the result
// register, one beat per cycle while the receiver pops, and marks the last one.
// ----------------------------------------------------------------------------
module kda_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  kda_pkg::tick_evt_t           head,
  output logic                         head_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic [kda_pkg::KEY_IDX_W-1:0] key_index,
  output logic                         is_make,
  output logic                         last_of_tick
);
  import kda_pkg::*;

  logic [EVT_KEYS-1:0]  done;
  logic [EVT_KEYS-1:0]  remaining;
  logic [KEY_IDX_W-1:0] sel;
  logic                 sel_last;
  logic                 out_valid;
  logic                 load;

  // Lowest pending key of the head record.
  always_comb begin
    remaining = head.hit & ~done;
    sel       = '0;
    for (int k = EVT_KEYS - 1; k >= 0; k--) begin
      if (remaining[k]) begin
        sel = KEY_IDX_W'(k);
      end
    end
    sel_last = ((remaining & ~(EVT_KEYS'(1) << sel)) == '0);
    load     = head_valid && (!out_valid || pop);
    head_pop = load && sel_last;
    empty    = !out_valid;
  end

  // Progress through the head record.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (load) begin
      if (sel_last) begin
        done <= '0;
      end else begin
        done[sel] <= 1'b1;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      key_index    <= sel;
      is_make      <= head.make[sel];
      last_of_tick <= sel_last;
    end
  end

endmodule

FILE: hdl/key_debounce_autorepeat.sv
// ----------------------------------------------------------------------------
// key_debounce_autorepeat
// Eight-key debouncer with auto-repeat: make, repeat and break events.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive key_levels (1 = pressed) with push; a scan
//   tick beat is taken when push is high and full is low.
//   Result side is a queue: while empty is low, key_index, is_make and
//   last_of_tick show the oldest event; pop takes the beat.
//   The user writes press_delay, hold_delay and repeat_period only while the
//   block is idle, through cfg_write, cfg_index and cfg_data; not enforced.
// Timing:
//   Key state is updated in the cycle a tick is taken, so a tick can be
//   taken every cycle while the four-entry tick queue has room.
//   The events of a tick pass through the tick queue and the result register.
//   The back part emits one event per cycle while the receiver pops;
//   ticks with no events use no queue entry.
// Reset and stalls:
//   rst clears key state, the queue and the result register, and loads the
//   register defaults. A stalled receiver holds the result register; ticks
//   keep being taken until the queue is full, then full is raised.
// ----------------------------------------------------------------------------
module key_debounce_autorepeat #(
  parameter int KEY_COUNT   = kda_pkg::KEY_COUNT_DEFAULT,
  parameter int COUNT_WIDTH = kda_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [kda_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kda_pkg::CFG_W-1:0]       cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [kda_pkg::LEVEL_W-1:0]     key_levels,
  output logic                           empty,
  input  logic                           pop,
  output logic [kda_pkg::KEY_IDX_W-1:0]   key_index,
  output logic                           is_make,
  output logic                           last_of_tick
);
  import kda_pkg::*;

  logic      accept;
  logic      evt_push;
  tick_evt_t evt;
  logic      head_valid;
  tick_evt_t head;
  logic      head_pop;

  // A tick beat is taken whenever the queue has room.
  assign accept = push && !full;

  kda_front #(
    .KEY_COUNT   (KEY_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .key_levels (key_levels),
    .evt_push   (evt_push),
    .evt        (evt)
  );

  kda_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (evt_push),
    .push_data  (evt),
    .pop        (head_pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  kda_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .head_pop     (head_pop),
    .pop          (pop),
    .empty        (empty),
    .key_index    (key_index),
    .is_make      (is_make),
    .last_of_tick (last_of_tick)
  );

endmodule

FILE: hdl/kda_checker.sv
// ----------------------------------------------------------------------------
// kda_checker
// Port-level checks of the key debounce block, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_debounce_autorepeat_defines.svh"

module kda_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic [kda_pkg::KEY_IDX_W-1:0]   key_index,
  input logic                           is_make,
  input logic                           last_of_tick
);
  import kda_pkg::*;

  // A waiting result beat holds until it is taken.
  `KDA_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(key_index) && $stable(is_make) && $stable(last_of_tick))

  // Coming out of reset nothing is waiting and there is room for ticks.
  `KDA_ASSERT_NOW(a_reset_clear, $past(rst), empty && !full)

  // Within one tick, events follow at once and in rising key order.
  `KDA_ASSERT_NEXT(a_tick_order, pop && !empty && !last_of_tick, !empty && (key_index > $past(key_index)))

endmodule

bind key_debounce_autorepeat kda_checker u_kda_checker (.*);
